[rtl/core/trsp_pkg.sv]
package trsp_pkg;

  localparam int MAX_CITIES_DEF = 256;

  localparam int CITY_W  = 8;
  localparam int CNT_W   = 9;
  localparam int TOLL_W  = 8;
  localparam int DIST_W  = 17;
  localparam int EDGE_W  = TOLL_W + 1;
  localparam int CFG_W   = 9;
  localparam int CFGI_W  = 2;

  localparam logic [DIST_W-1:0] UNREACH = DIST_W'(100000);

  localparam logic [CFGI_W-1:0] CFG_CITY_COUNT   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_ROUTE_LENGTH = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_START_CITY   = 2'd2;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

endpackage

[rtl/core/trsp_ram.sv]
module trsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/toll_route_shortest_path.sv]
// Toll route shortest path engine.
// Input channel (in_valid/in_ready): each transfer carries one item. A kind
// add item stores one toll road in the edge memory, in one direction or,
// through S_LOAD2, in both, and not at all if the rules refuse it. A kind
// solve item runs a queue-driven relaxation from start_city, or emits UNREACH
// for a bad setup, and produces one distance transfer on out_valid/out_ready.
// A solve first presets the cost table for the n cities in use (S_INIT),
// then, for every city taken from the work queue, passes S_DEQ, S_DEQ2 and
// S_DEQ3 and checks its n neighbors one at a time in S_RD and S_CMP, through
// the edge memory read port and the single add-and-compare unit.
// After each solve, and after reset, the edge memory and the queue marks are
// swept clean at one entry a cycle over all edge memory entries (65536 by
// default), and in_ready stays low during the sweep. Configuration writes
// are taken at any time and must only be made while no item is in flight.
// Reset (rst_n low at a clock edge) clears the queue and the output valid,
// sets city count and route length to 1 and start city to 0, and starts the sweep.
// The result sits in an output register; a stalled receiver holds it there
// while new add items are still taken, and a second solve waits for it.
module toll_route_shortest_path
  import trsp_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [CITY_W-1:0] in_from_city,
  input  logic [CITY_W-1:0] in_to_city,
  input  logic [TOLL_W-1:0] in_toll,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance
);

  localparam int CW    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CXW   = (CW > CITY_W) ? CW : CITY_W;
  localparam int NW0   = $clog2(MAX_CITIES + 1);
  localparam int NW    = (NW0 > CNT_W) ? NW0 : CNT_W;
  localparam int EAW   = 2 * CW;
  localparam int EDEPTH = 1 << EAW;
  localparam int CW0   = $clog2(255 * MAX_CITIES + 1);
  localparam int CST_W = (CW0 > DIST_W) ? CW0 : DIST_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD2, S_INIT, S_START, S_DEQ, S_DEQ2, S_DEQ3,
    S_RD, S_CMP, S_TGT, S_EMIT
  } state_t;

  state_t             state_r;
  logic [EAW-1:0]     clr_cnt_r;
  logic [EAW-1:0]     ld_addr_r;
  logic [TOLL_W-1:0]  ld_toll_r;
  logic [CNT_W-1:0]   city_count_r;
  logic [CNT_W-1:0]   route_length_r;
  logic [CITY_W-1:0]  start_city_r;
  logic [CW-1:0]      i_r;
  logic [CW-1:0]      u_r;
  logic [CST_W-1:0]   bu_r;
  logic [CST_W-1:0]   dist_r;
  logic [CW-1:0]      head_r;
  logic [CW-1:0]      tail_r;
  logic [NW-1:0]      count_r;
  logic               out_valid_r;
  logic [DIST_W-1:0]  out_distance_r;

  logic [CXW-1:0]     u_x;
  logic [CXW-1:0]     v_x;
  logic               road_ok;
  logic               u_off;
  logic               v_off;
  logic               adj;
  logic               wr_first;
  logic               wr_second;
  logic [EAW-1:0]     addr_uv;
  logic [EAW-1:0]     addr_vu;
  logic [NW-1:0]      n_w;
  logic [NW-1:0]      tgt_w;
  logic [CXW-1:0]     start_x;
  logic               bad_solve;
  logic               last_i;
  logic [CW-1:0]      head_inc;
  logic [CW-1:0]      tail_inc;
  logic [CST_W-1:0]   cand;
  logic               edge_ok;
  logic               upd;
  logic               enq;
  logic               accept;

  logic               e_we;
  logic [EAW-1:0]     e_waddr;
  logic [EDGE_W-1:0]  e_wdata;
  logic [EDGE_W-1:0]  e_rdata;
  logic               b_we;
  logic [CW-1:0]      b_waddr;
  logic [CST_W-1:0]   b_wdata;
  logic [CW-1:0]      b_raddr;
  logic [CST_W-1:0]   b_rdata;
  logic               q_we;
  logic [CW-1:0]      q_waddr;
  logic [CW-1:0]      q_wdata;
  logic [CW-1:0]      q_rdata;
  logic               m_we;
  logic [CW-1:0]      m_waddr;
  logic               m_wdata;
  logic               m_rdata;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_ready = (state_r == S_IDLE);

  assign u_x     = CXW'(in_from_city);
  assign v_x     = CXW'(in_to_city);
  assign road_ok = ({1'b0, u_x} < (CXW+1)'(MAX_CITIES)) &&
                   ({1'b0, v_x} < (CXW+1)'(MAX_CITIES));
  assign u_off   = CNT_W'(in_from_city) >= route_length_r;
  assign v_off   = CNT_W'(in_to_city) >= route_length_r;
  assign adj     = (CNT_W'(in_from_city) + 1'b1 == CNT_W'(in_to_city)) ||
                   (CNT_W'(in_to_city) + 1'b1 == CNT_W'(in_from_city));
  assign wr_first  = road_ok && (u_off || v_off || adj);
  assign wr_second = road_ok && ((u_off && v_off) || (!u_off && !v_off && adj));
  assign addr_uv   = {u_x[CW-1:0], v_x[CW-1:0]};
  assign addr_vu   = {v_x[CW-1:0], u_x[CW-1:0]};

  assign n_w       = (NW'(city_count_r) < NW'(MAX_CITIES)) ? NW'(city_count_r)
                                                            : NW'(MAX_CITIES);
  assign tgt_w     = NW'(route_length_r) - 1'b1;
  assign start_x   = CXW'(start_city_r);
  assign bad_solve = (NW'(start_city_r) >= n_w) || (route_length_r == '0) ||
                     (tgt_w >= n_w);
  assign last_i    = (NW'(i_r) == n_w - 1'b1);

  assign head_inc = (head_r == CW'(MAX_CITIES - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == CW'(MAX_CITIES - 1)) ? '0 : tail_r + 1'b1;

  assign cand    = bu_r + CST_W'(e_rdata[TOLL_W-1:0]);
  assign edge_ok = e_rdata[EDGE_W-1];
  assign upd     = (state_r == S_CMP) && edge_ok && (b_rdata > cand);
  assign enq     = upd && !m_rdata;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = addr_uv;
    e_wdata = {1'b1, in_toll};
    case (state_r)
      S_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_cnt_r;
        e_wdata = '0;
      end
      S_IDLE: begin
        e_we    = accept && (in_kind == KIND_ADD) && wr_first;
        e_waddr = (!u_off && v_off) ? addr_vu : addr_uv;
      end
      S_LOAD2: begin
        e_we    = 1'b1;
        e_waddr = ld_addr_r;
        e_wdata = {1'b1, ld_toll_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    b_we    = 1'b0;
    b_waddr = i_r;
    b_wdata = cand;
    b_raddr = i_r;
    q_we    = enq;
    q_waddr = tail_r;
    q_wdata = i_r;
    m_we    = 1'b0;
    m_waddr = i_r;
    m_wdata = 1'b1;
    case (state_r)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_cnt_r[CW-1:0];
        m_wdata = 1'b0;
      end
      S_INIT: begin
        b_we    = 1'b1;
        b_wdata = CST_W'(UNREACH);
      end
      S_START: begin
        b_we    = 1'b1;
        b_waddr = start_x[CW-1:0];
        b_wdata = '0;
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = start_x[CW-1:0];
        m_we    = 1'b1;
        m_waddr = start_x[CW-1:0];
      end
      S_DEQ: begin
        b_raddr = tgt_w[CW-1:0];
      end
      S_DEQ2: begin
        b_raddr = q_rdata;
        m_we    = 1'b1;
        m_waddr = q_rdata;
        m_wdata = 1'b0;
      end
      S_CMP: begin
        b_we = upd;
        m_we = enq;
      end
      default: begin
      end
    endcase
  end

  trsp_ram #(.WIDTH(EDGE_W), .DEPTH(EDEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr ({u_r, i_r}),
    .rdata (e_rdata)
  );

  trsp_ram #(.WIDTH(CST_W), .DEPTH(MAX_CITIES)) u_cost_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  trsp_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  trsp_ram #(.WIDTH(1), .DEPTH(MAX_CITIES)) u_mark_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (i_r),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      city_count_r   <= CNT_W'(1);
      route_length_r <= CNT_W'(1);
      start_city_r   <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CITY_COUNT:   city_count_r   <= cfg_wdata;
          CFG_ROUTE_LENGTH: route_length_r <= cfg_wdata;
          CFG_START_CITY:   start_city_r   <= cfg_wdata[CITY_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == EAW'(EDEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_kind == KIND_ADD) begin
              ld_addr_r <= addr_vu;
              ld_toll_r <= in_toll;
              if (wr_second) begin
                state_r <= S_LOAD2;
              end
            end else if (bad_solve) begin
              dist_r  <= CST_W'(UNREACH);
              state_r <= S_EMIT;
            end else begin
              i_r     <= '0;
              state_r <= S_INIT;
            end
          end
        end
        S_LOAD2: begin
          state_r <= S_IDLE;
        end
        S_INIT: begin
          i_r <= i_r + 1'b1;
          if (last_i) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          head_r  <= '0;
          tail_r  <= (MAX_CITIES > 1) ? CW'(1) : '0;
          count_r <= NW'(1);
          state_r <= S_DEQ;
        end
        S_DEQ: begin
          if (count_r == '0) begin
            state_r <= S_TGT;
          end else begin
            head_r  <= head_inc;
            count_r <= count_r - 1'b1;
            state_r <= S_DEQ2;
          end
        end
        S_DEQ2: begin
          u_r     <= q_rdata;
          state_r <= S_DEQ3;
        end
        S_DEQ3: begin
          bu_r    <= b_rdata;
          i_r     <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (enq) begin
            tail_r  <= tail_inc;
            count_r <= count_r + 1'b1;
          end
          if (last_i) begin
            state_r <= S_DEQ;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_TGT: begin
          dist_r  <= b_rdata;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_distance_r <= dist_r[DIST_W-1:0];
            clr_cnt_r      <= '0;
            state_r        <= S_CLEAR;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

[rtl/core/trsp_checker.sv]
module trsp_checker
  import trsp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] out_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("Pending result transfer changed before it was taken.");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= UNREACH)
    else $error("Distance is above the unreachable code.");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_SOLVE |=> !in_ready)
    else $error("Input was ready right after a solve transfer.");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("Block was ready or showed a result right after reset.");

endmodule

bind toll_route_shortest_path trsp_checker u_trsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_kind      (in_kind),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_distance (out_distance)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import trsp_pkg::*;

  localparam int CITIES = MAX_CITIES_DEF;
  localparam int unsigned SWEEP_CYCLES = CITIES * CITIES;
  localparam int unsigned HOLD_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = CFG_CITY_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_ADD;
  logic [CITY_W-1:0] in_from_city = '0;
  logic [CITY_W-1:0] in_to_city = '0;
  logic [TOLL_W-1:0] in_toll = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] out_distance;

  logic [EDGE_W-1:0] road_mem [CITIES*CITIES];
  logic [CNT_W-1:0] cfg_cities = CNT_W'(1);
  logic [CNT_W-1:0] cfg_route = CNT_W'(1);
  logic [CITY_W-1:0] cfg_start = '0;
  logic [DIST_W-1:0] expected_distances [$];

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 62;
  int unsigned stall_limit = 4 * (SWEEP_CYCLES + 2000) + 2 * HOLD_CYCLES;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  bit hold_off = 1'b0;

  toll_route_shortest_path dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_from_city(in_from_city),
    .in_to_city  (in_to_city),
    .in_toll     (in_toll),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_distance(out_distance)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_roads();
    for (int i = 0; i < CITIES * CITIES; i++) road_mem[i] = '0;
  endfunction

  function automatic void put_road(input int unsigned a, input int unsigned b,
                                   input int unsigned toll);
    road_mem[a * CITIES + b] = {1'b1, TOLL_W'(toll)};
  endfunction

  function automatic void store_road(input int unsigned u, input int unsigned v,
                                     input int unsigned toll);
    bit u_off;
    bit v_off;
    u_off = u >= int'(cfg_route);
    v_off = v >= int'(cfg_route);
    if (u_off && v_off) begin
      put_road(u, v, toll);
      put_road(v, u, toll);
    end else if (u_off) begin
      put_road(u, v, toll);
    end else if (v_off) begin
      put_road(v, u, toll);
    end else if (u + 1 == v || v + 1 == u) begin
      put_road(u, v, toll);
      put_road(v, u, toll);
    end
  endfunction

  function automatic logic [DIST_W-1:0] cheapest_toll(output int unsigned pops,
                                                      output int unsigned used);
    int unsigned head;
    int unsigned count;
    int unsigned u;
    int unsigned c;
    int unsigned route_len;
    int unsigned origin;
    logic [DIST_W-1:0] best [CITIES];
    bit queued [CITIES];
    int unsigned fifo [CITIES];
    logic [EDGE_W-1:0] e;
    pops = 0;
    route_len = cfg_route;
    origin = cfg_start;
    used = (cfg_cities < CITIES) ? cfg_cities : CITIES;
    if (origin >= used || route_len == 0 || route_len - 1 >= used) return UNREACH;
    for (int i = 0; i < used; i++) begin
      best[i] = UNREACH;
      queued[i] = 1'b0;
    end
    best[origin] = '0;
    fifo[0] = origin;
    queued[origin] = 1'b1;
    head = 0;
    count = 1;
    while (count > 0) begin
      u = fifo[head];
      head = (head + 1) % CITIES;
      count--;
      queued[u] = 1'b0;
      pops++;
      for (int i = 0; i < used; i++) begin
        e = road_mem[u * CITIES + i];
        if (e[TOLL_W]) begin
          c = best[u] + e[TOLL_W-1:0];
          if (best[i] > c) begin
            best[i] = DIST_W'(c);
            if (!queued[i]) begin
              fifo[(head + count) % CITIES] = i;
              count++;
              queued[i] = 1'b1;
            end
          end
        end
      end
    end
    return best[route_len - 1];
  endfunction

  task automatic send_item(input logic kind, input int unsigned from_city,
                           input int unsigned to_city, input int unsigned toll);
    int unsigned pops;
    int unsigned used;
    int unsigned budget;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_from_city <= CITY_W'(from_city);
    in_to_city <= CITY_W'(to_city);
    in_toll <= TOLL_W'(toll);
    do @(posedge clk); while (in_ready !== 1'b1);
    if (kind == KIND_ADD) begin
      store_road(from_city, to_city, toll);
    end else begin
      expected_distances.push_back(cheapest_toll(pops, used));
      clear_roads();
      budget = 4 * (SWEEP_CYCLES + used + pops * (3 + 2 * used)) + 2 * HOLD_CYCLES;
      if (budget > stall_limit) stall_limit = budget;
    end
  endtask

  task automatic add_road(input int unsigned u, input int unsigned v,
                          input int unsigned toll);
    send_item(KIND_ADD, u, v, toll);
  endtask

  task automatic solve_now();
    send_item(KIND_SOLVE, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFGI_W-1:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      CFG_CITY_COUNT:   cfg_cities = CNT_W'(value);
      CFG_ROUTE_LENGTH: cfg_route = CNT_W'(value);
      CFG_START_CITY:   cfg_start = CITY_W'(value);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_problem(input int unsigned cities, input int unsigned route,
                             input int unsigned origin);
    wait_idle();
    write_cfg(CFG_CITY_COUNT, cities);
    write_cfg(CFG_ROUTE_LENGTH, route);
    write_cfg(CFG_START_CITY, origin);
  endtask

  function automatic int unsigned pick_city(input int unsigned lo, input int unsigned hi,
                                            input int unsigned used);
    if (lo < hi) return $urandom_range(hi - 1, lo);
    return $urandom_range(used - 1);
  endfunction

  task automatic test_direction_rules();
    set_problem(6, 3, 5);
    add_road(5, 4, 10);
    add_road(4, 0, 3);
    add_road(0, 2, 1);
    add_road(0, 1, 7);
    add_road(2, 1, 4);
    add_road(2, 3, 50);
    solve_now();
    set_problem(5, 2, 0);
    add_road(0, 3, 5);
    add_road(3, 1, 5);
    solve_now();
  endtask

  task automatic test_special_cases();
    set_problem(4, 2, 0);
    add_road(0, 1, 9);
    add_road(1, 0, 4);
    solve_now();
    solve_now();
    set_problem(3, 2, 3);
    add_road(0, 1, 1);
    solve_now();
    set_problem(3, 5, 0);
    add_road(0, 1, 1);
    solve_now();
    set_problem(4, 0, 0);
    add_road(0, 1, 2);
    solve_now();
    set_problem(4, 2, 3);
    add_road(3, 5, 1);
    add_road(5, 1, 1);
    solve_now();
  endtask

  task automatic test_extremes();
    set_problem(256, 255, 255);
    add_road(255, 254, 255);
    add_road(255, 0, 0);
    solve_now();
    set_problem(256, 256, 255);
    solve_now();
  endtask

  task automatic random_problem(input int unsigned max_cities, input int unsigned roads);
    int unsigned n;
    int unsigned used;
    int unsigned r;
    int unsigned on_top;
    int unsigned u;
    int unsigned v;
    int unsigned t;
    n = $urandom_range(max_cities, 2);
    if (max_cities == CITIES && $urandom_range(3) == 0) n = $urandom_range(511, 257);
    used = (n < CITIES) ? n : CITIES;
    case ($urandom_range(11))
      0: r = 0;
      1: r = $urandom_range(511, used + 1);
      default: r = $urandom_range(used, 1);
    endcase
    on_top = (r < used) ? r : used;
    if ($urandom_range(11) == 0) set_problem(n, r, $urandom_range(255));
    else set_problem(n, r, $urandom_range(used - 1));
    repeat (roads) begin
      case ($urandom_range(9))
        0, 1: begin
          u = $urandom_range(255);
          v = $urandom_range(255);
        end
        2, 3: begin
          u = (on_top >= 2) ? $urandom_range(on_top - 2) : $urandom_range(used - 1);
          v = (on_top >= 2) ? u + 1 : $urandom_range(used - 1);
        end
        4, 5: begin
          u = pick_city(r, used, used);
          v = pick_city(0, on_top, used);
        end
        6, 7: begin
          u = pick_city(r, used, used);
          v = pick_city(r, used, used);
        end
        default: begin
          u = $urandom_range(used - 1);
          v = $urandom_range(used - 1);
        end
      endcase
      t = $urandom_range(255);
      if ($urandom_range(1)) add_road(u, v, t);
      else add_road(v, u, t);
    end
    solve_now();
  endtask

  task automatic test_random_problems(input int unsigned problems, input int unsigned sidle,
                                      input int unsigned ridle, input bit big_first);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int p = 0; p < problems; p++) begin
      if (big_first && p == 0) random_problem(CITIES, 150);
      else random_problem(32, $urandom_range(110, 50));
    end
  endtask

  task automatic test_output_backpressure();
    set_problem(10, 4, 6);
    hold_off = 1'b1;
    repeat (8) add_road($urandom_range(9), $urandom_range(9), $urandom_range(255));
    solve_now();
    repeat (8) add_road($urandom_range(9), $urandom_range(9), $urandom_range(255));
    solve_now();
    repeat (4) add_road($urandom_range(9), $urandom_range(9), $urandom_range(255));
    solve_now();
  endtask

  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_distances.size() == 0) begin
        $error("distance: expected no transfer, actual %0d", out_distance);
        mismatches++;
      end else begin
        want = expected_distances.pop_front();
        if (out_distance !== want) begin
          $error("distance: expected %0d, actual %0d", want, out_distance);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= stall_limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clear_roads();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_direction_rules();
    test_special_cases();
    test_extremes();
    test_random_problems(7, 37, 62, 1'b1);
    test_random_problems(7, 62, 37, 1'b1);
    test_random_problems(6, 0, 0, 1'b0);
    test_output_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
